@@ src/svbg_pkg.sv @@
// Shared constants and types for the strided vector base generator.
// No dependencies; imported by svbg_cfg, strided_vector_base_generator_top and tb.
package svbg_pkg;

  localparam int NUM_AXES   = 4;
  localparam int AX_W       = $clog2(NUM_AXES);
  localparam int OFS_W      = 48;
  localparam int LEN_W      = 16;
  localparam int RAW_W      = 32;
  localparam int OS_W       = 32;
  localparam int TL_W       = 48;
  localparam int ND_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = OFS_W + OFS_W + LEN_W;

  typedef logic [NUM_AXES-1:0][LEN_W-1:0] cnt_vec_t;
  typedef logic [NUM_AXES-1:0][OFS_W-1:0] ofs_vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_SIZES,
    REG_STRIDES_LO,
    REG_STRIDES_HI,
    REG_NUM_DIMS,
    REG_TRANSFORM_DIM,
    REG_OUTER_STRIDE,
    REG_TOTAL_LENGTH
  } cfg_reg_t;

  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_t;

  // Configuration view handed to the stepping datapath, plus the
  // advance-delta write port used while the derived values are rebuilt.
  typedef struct packed {
    logic                busy;
    logic [NUM_AXES-1:0] act;
    logic [AX_W-1:0]     tdim;
    logic [OS_W-1:0]     os;
    cnt_vec_t            len;
    ofs_vec_t            stride;
    logic [OFS_W-1:0]    step;
    logic [OFS_W-1:0]    flat_init;
    logic                e_wr;
    logic [AX_W-1:0]     e_idx;
    logic [OFS_W-1:0]    e_val;
  } cfg_derived_t;

endpackage

@@ src/svbg_cfg.sv @@
// Configuration registers and the derived-value sequencer (one shared
// 32x32 multiplier, one product per cycle). Depends on svbg_pkg.
module svbg_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [svbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [svbg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  svbg_pkg::cnt_vec_t             cnt,
  output svbg_pkg::cfg_derived_t         cf
);
  import svbg_pkg::*;

  typedef enum logic [3:0] {
    SQ_STR0, SQ_STR1, SQ_STR2, SQ_STR3,
    SQ_STEP, SQ_FLAT_LO, SQ_FLAT_HI,
    SQ_E0, SQ_P0, SQ_E1, SQ_P1, SQ_E2, SQ_P2, SQ_E3, SQ_P3
  } seq_t;

  seq_t                         seq_r;
  logic                         busy_r;
  logic [CFG_DATA_W-1:0]        sizes_r;
  logic [CFG_DATA_W-1:0]        str_lo_r;
  logic [CFG_DATA_W-1:0]        str_hi_r;
  logic [ND_W-1:0]              nd_r;
  logic [AX_W-1:0]              tdim_r;
  logic [OS_W-1:0]              os_r;
  logic [TL_W-1:0]              tl_r;
  ofs_vec_t                     stride_r;
  logic [OFS_W-1:0]             step_r;
  logic [OFS_W-1:0]             flat_r;
  logic [OFS_W-1:0]             p_r;

  logic [NUM_AXES-1:0][RAW_W-1:0] raw;
  cnt_vec_t                     len;
  logic [ND_W-1:0]              n_eff;
  logic [NUM_AXES-1:0]          act;
  logic [3:0]                   seq_off;
  logic [AX_W-1:0]              ax;
  logic                         is_e;
  logic [RAW_W-1:0]             mul_a;
  logic [RAW_W-1:0]             mul_b;
  logic [2*RAW_W-1:0]           prod;
  logic [OFS_W-1:0]             prod_hi_sh;

  assign cfg_ready = 1'b1;
  assign raw = {str_hi_r, str_lo_r};
  assign len = sizes_r;

  always_comb begin
    n_eff = nd_r;
    if (nd_r == '0) begin
      n_eff = ND_W'(1);
    end else if (nd_r > ND_W'(NUM_AXES)) begin
      n_eff = ND_W'(NUM_AXES);
    end
    for (int m = 0; m < NUM_AXES; m++) begin
      act[m] = (AX_W'(m) != tdim_r) && (ND_W'(m) < n_eff);
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    seq_off = 4'(seq_r) - 4'(SQ_E0);
    ax      = '0;
    is_e    = 1'b0;
    mul_a   = os_r;
    mul_b   = os_r;
    unique case (seq_r) inside
      SQ_STR0, SQ_STR1, SQ_STR2, SQ_STR3: begin
        ax    = AX_W'(seq_r);
        mul_a = raw[ax];
      end
      SQ_STEP: begin
        mul_b = RAW_W'(len[0]);
      end
      SQ_FLAT_LO: begin
        mul_a = tl_r[RAW_W-1:0];
      end
      SQ_FLAT_HI: begin
        mul_a = RAW_W'(tl_r[TL_W-1:RAW_W]);
      end
      SQ_E0, SQ_E1, SQ_E2, SQ_E3: begin
        is_e  = 1'b1;
        ax    = seq_off[AX_W:1];
        mul_a = stride_r[ax][RAW_W-1:0];
        mul_b = RAW_W'(cnt[ax]);
      end
      SQ_P0, SQ_P1, SQ_P2, SQ_P3: begin
        ax    = seq_off[AX_W:1];
        mul_a = RAW_W'(stride_r[ax][OFS_W-1:RAW_W]);
        mul_b = RAW_W'(cnt[ax]);
      end
      default: ;
    endcase
    prod       = (2*RAW_W)'(mul_a) * (2*RAW_W)'(mul_b);
    prod_hi_sh = {prod[OFS_W-RAW_W-1:0], {RAW_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= SQ_STR0;
      busy_r   <= 1'b1;
      sizes_r  <= 64'h0001_0001_0001_0001;
      str_lo_r <= '0;
      str_hi_r <= '0;
      nd_r     <= ND_W'(1);
      tdim_r   <= '0;
      os_r     <= OS_W'(1);
      tl_r     <= '0;
    end else if (cfg_valid) begin
      // restart the rebuild on every write
      seq_r  <= SQ_STR0;
      busy_r <= 1'b1;
      unique case (cfg_reg_t'(cfg_index))
        REG_DIM_SIZES:     sizes_r  <= cfg_data;
        REG_STRIDES_LO:    str_lo_r <= cfg_data;
        REG_STRIDES_HI:    str_hi_r <= cfg_data;
        REG_NUM_DIMS:      nd_r     <= cfg_data[ND_W-1:0];
        REG_TRANSFORM_DIM: tdim_r   <= cfg_data[AX_W-1:0];
        REG_OUTER_STRIDE:  os_r     <= cfg_data[OS_W-1:0];
        REG_TOTAL_LENGTH:  tl_r     <= cfg_data[TL_W-1:0];
        default: ;
      endcase
    end else if (busy_r) begin
      unique case (seq_r) inside
        SQ_STR0, SQ_STR1, SQ_STR2, SQ_STR3: stride_r[ax] <= prod[OFS_W-1:0];
        SQ_STEP:    step_r <= prod[OFS_W-1:0];
        SQ_FLAT_LO: begin
          flat_r <= prod[OFS_W-1:0];
          p_r    <= '0;
        end
        SQ_FLAT_HI: flat_r <= flat_r + prod_hi_sh;
        // accumulate count times stride over the active axes below each axis
        SQ_E0, SQ_E1, SQ_E2, SQ_E3: begin
          if (act[ax]) p_r <= p_r + prod[OFS_W-1:0];
        end
        SQ_P0, SQ_P1, SQ_P2, SQ_P3: begin
          if (act[ax]) p_r <= p_r + prod_hi_sh;
        end
        default: ;
      endcase
      if (seq_r == SQ_P3) begin
        busy_r <= 1'b0;
      end else begin
        seq_r <= seq_t'(4'(seq_r) + 4'd1);
      end
    end
  end

  always_comb begin
    cf.busy      = busy_r;
    cf.act       = act;
    cf.tdim      = tdim_r;
    cf.os        = os_r;
    cf.len       = len;
    cf.stride    = stride_r;
    cf.step      = step_r;
    cf.flat_init = flat_r;
    cf.e_wr      = busy_r && is_e;
    cf.e_idx     = ax;
    cf.e_val     = stride_r[ax] - p_r;
  end

endmodule

@@ src/strided_vector_base_generator_top.sv @@
// Strided vector base generator: input register, one-pass stepping logic,
// result register. Depends on svbg_pkg and svbg_cfg.
//
//  channel | direction | beat                                     | handshake
//  in_     | sink      | tuser=func, tdata=start_offset           | in_tvalid/in_tready
//  out_    | source    | tuser=valid_res, tdata=offset/stride/len | out_tvalid/out_tready
//  cfg_    | sink      | cfg_index, cfg_data                      | cfg_valid/cfg_ready
//
// One beat in and one beat out per cycle unless a rebuild or a low out_tready stalls;
// each beat passes the input register, then the result register. Reset and every
// config write start a rebuild of the scaled strides and offsets on the single
// shared multiplier; in_tready stays low during it. With out_tready low the result
// holds and one more beat waits in the input register. cfg_ready is always high.
module strided_vector_base_generator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [svbg_pkg::IN_TDATA_W-1:0]   in_tdata,   // [47:0] start_offset
  input  logic                              in_tuser,   // [0] func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [47:0] vector_offset, [95:48] vector_stride, [111:96] vector_length
  output logic [svbg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tuser,  // [0] valid_res
  output logic                              out_tlast,  // last
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [svbg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svbg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import svbg_pkg::*;

  cfg_derived_t         cf;

  logic                 in_v_r;
  func_t                in_func_r;
  logic [OFS_W-1:0]     in_start_r;
  logic                 out_v_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                 out_ok_r;
  logic                 out_last_r;

  cnt_vec_t             cnt_r;
  cnt_vec_t             cnt_nxt;
  ofs_vec_t             e_r;
  ofs_vec_t             e_nxt;
  logic [OFS_W-1:0]     off_r;
  logic [OFS_W-1:0]     off_nxt;
  logic [OFS_W-1:0]     lim_r;
  logic [OFS_W-1:0]     lim_nxt;
  logic                 sweep_r;
  logic                 sweep_nxt;

  logic                 adv;
  logic                 flat;
  logic [NUM_AXES-1:0]  hit;
  logic                 found;
  logic [AX_W-1:0]      k;
  logic                 res_ok;
  logic                 res_last;
  logic [OFS_W-1:0]     res_stride;
  logic [OUT_TDATA_W-1:0] res_data;

  function automatic logic last_of(input cnt_vec_t c, input logic [NUM_AXES-1:0] a,
                                   input cnt_vec_t l);
    logic r;
    r = 1'b1;
    for (int m = 0; m < NUM_AXES; m++) begin
      if (a[m] && (({1'b0, c[m]} + (LEN_W+1)'(1)) < {1'b0, l[m]})) r = 1'b0;
    end
    return r;
  endfunction

  svbg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cnt       (cnt_r),
    .cf        (cf)
  );

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !cf.busy && (!in_v_r || adv);

  always_comb begin
    flat = (cf.tdim == '0);
    for (int m = 0; m < NUM_AXES; m++) begin
      hit[m] = cf.act[m] && (({1'b0, cnt_r[m]} + (LEN_W+1)'(1)) < {1'b0, cf.len[m]});
    end
    found = |hit;
    k = '0;
    for (int m = NUM_AXES - 1; m >= 0; m--) begin
      if (hit[m]) k = AX_W'(m);
    end

    cnt_nxt   = cnt_r;
    e_nxt     = e_r;
    off_nxt   = off_r;
    lim_nxt   = lim_r;
    sweep_nxt = sweep_r;
    res_ok    = 1'b0;
    res_last  = 1'b0;

    if (in_func_r == FUNC_START) begin
      cnt_nxt = '0;
      e_nxt   = cf.stride;
      off_nxt = in_start_r;
      if (flat) begin
        lim_nxt  = cf.flat_init;
        res_ok   = (cf.flat_init != '0);
        res_last = (cf.flat_init <= cf.step);
      end else begin
        res_ok   = 1'b1;
        res_last = last_of('0, cf.act, cf.len);
      end
      sweep_nxt = res_ok && !res_last;
    end else if (sweep_r) begin
      if (flat) begin
        if (cf.step >= lim_r) begin
          lim_nxt   = '0;
          sweep_nxt = 1'b0;
        end else begin
          lim_nxt   = lim_r - cf.step;
          off_nxt   = off_r + cf.step;
          res_ok    = 1'b1;
          // remaining span after this step is within one more step
          res_last  = ({1'b0, lim_r} <= {cf.step, 1'b0});
          sweep_nxt = !res_last;
        end
      end else begin
        // wrap every active axis below the one that advances
        for (int m = 0; m < NUM_AXES; m++) begin
          if (cf.act[m] && (!found || (AX_W'(m) < k))) cnt_nxt[m] = '0;
          if (!found || (AX_W'(m) <= k)) begin
            e_nxt[m] = cf.stride[m];
          end else begin
            e_nxt[m] = e_r[m] - e_r[k];
          end
        end
        if (found) begin
          cnt_nxt[k] = cnt_r[k] + LEN_W'(1);
          off_nxt    = off_r + e_r[k];
          res_ok     = 1'b1;
          res_last   = last_of(cnt_nxt, cf.act, cf.len);
          sweep_nxt  = !res_last;
        end else begin
          sweep_nxt = 1'b0;
        end
      end
    end

    res_stride = flat ? OFS_W'(cf.os) : cf.stride[cf.tdim];
    res_data   = res_ok ? {cf.len[cf.tdim], res_stride, off_nxt} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
      off_r   <= '0;
      lim_r   <= '0;
      sweep_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
        cnt_r   <= cnt_nxt;
        off_r   <= off_nxt;
        lim_r   <= lim_nxt;
        sweep_r <= sweep_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r  <= func_t'(in_tuser);
      in_start_r <= in_tdata;
    end
    if (cf.e_wr) begin
      e_r[cf.e_idx] <= cf.e_val;
    end else if (adv) begin
      e_r <= e_nxt;
    end
    if (adv) begin
      out_data_r <= res_data;
      out_ok_r   <= res_ok;
      out_last_r <= res_ok && res_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;
  assign out_tlast  = out_last_r;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for strided_vector_base_generator_top: a directed
// table, then random sweeps over random axis setups, checked beat by beat.
// Depends on svbg_pkg for the register and function codes.
module tb;
  import svbg_pkg::*;

  typedef struct packed {
    logic             valid;
    logic [OFS_W-1:0] offset;
    logic [OFS_W-1:0] stride;
    logic [LEN_W-1:0] len;
    logic             is_last;
  } vec_res_t;

  typedef struct {
    bit        is_cfg;
    cfg_reg_t  idx;
    bit [63:0] data;
    func_t     func;
    bit [47:0] ofs;
    bit        typed;
    vec_res_t  want;
  } dir_row_t;

  localparam vec_res_t NO_VEC = '0;
  localparam bit [47:0] OFS_MAX = 48'hFFFF_FFFF_FFFF;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [47:0] start_offset
  logic                   in_tuser;   // [0] func
  logic                   out_tvalid;
  logic                   out_tready;
  // [47:0] vector_offset, [95:48] vector_stride, [111:96] vector_length
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;  // [0] valid_res
  logic                   out_tlast;  // last
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  strided_vector_base_generator_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow registers and sweep state of the generator
  bit [63:0]      sh_sizes, sh_str_lo, sh_str_hi;
  bit [2:0]       sh_ndims;
  bit [1:0]       sh_tdim;
  bit [31:0]      sh_outer;
  bit [47:0]      sh_total;
  bit [15:0]      axis_cnt [NUM_AXES];
  bit [47:0]      cur_ofs, flat_left;
  bit             sweep_on;

  vec_res_t       pending_vecs [$];
  vec_res_t       head_vec;
  dir_row_t       dir_rows [$];
  int             mismatches, items_sent, results_seen, cfg_writes, settings_used;
  int             directed_items;
  bit             quiet_phase;

  function automatic bit [31:0] axis_len(int i);
    return {16'b0, sh_sizes[16*i +: 16]};
  endfunction

  function automatic bit [47:0] axis_stride(int i);
    bit [31:0] raw;
    bit [63:0] prod;
    raw  = (i < 2) ? sh_str_lo[32*i +: 32] : sh_str_hi[32*(i-2) +: 32];
    prod = 64'(raw) * 64'(sh_outer);
    return prod[47:0];
  endfunction

  function automatic int axes_in_use();
    int n;
    n = int'(sh_ndims);
    if (n == 0) n = 1;
    if (n > NUM_AXES) n = NUM_AXES;
    return n;
  endfunction

  function automatic bit odo_at_end(int r);
    for (int i = 0; i < axes_in_use(); i++)
      if (i != r && {16'b0, axis_cnt[i]} + 32'd1 < axis_len(i)) return 1'b0;
    return 1'b1;
  endfunction

  // Step the odometer over every axis but r; return 0 once all of them wrapped.
  function automatic bit odo_step(int r);
    bit [47:0] s;
    bit [31:0] c;
    for (int i = 0; i < axes_in_use(); i++) begin
      if (i == r) continue;
      s = axis_stride(i);
      c = {16'b0, axis_cnt[i]} + 32'd1;
      cur_ofs = cur_ofs + s;
      if (c < axis_len(i)) begin
        axis_cnt[i] = c[15:0];
        return 1'b1;
      end
      cur_ofs = cur_ofs - s * 48'(c);
      axis_cnt[i] = '0;
    end
    return 1'b0;
  endfunction

  function automatic vec_res_t next_vector(func_t f, bit [47:0] ofs);
    vec_res_t  res;
    int        r;
    bit        flat, fin;
    bit [47:0] step;
    res  = NO_VEC;
    r    = int'(sh_tdim);
    flat = (r == 0);
    step = 48'(sh_outer) * 48'(axis_len(0));
    if (f == FUNC_START) begin
      for (int i = 0; i < NUM_AXES; i++) axis_cnt[i] = '0;
      cur_ofs = ofs;
      if (flat) begin
        flat_left = sh_total * 48'(sh_outer);
        if (flat_left == 0) begin
          sweep_on = 1'b0;
          return res;
        end
        fin = (flat_left <= step);
      end else begin
        fin = odo_at_end(r);
      end
    end else begin
      if (!sweep_on) return res;
      if (flat) begin
        if (step >= flat_left) begin
          flat_left = '0;
          sweep_on  = 1'b0;
          return res;
        end
        flat_left = flat_left - step;
        cur_ofs   = cur_ofs + step;
        fin       = (flat_left <= step);
      end else begin
        if (!odo_step(r)) begin
          sweep_on = 1'b0;
          return res;
        end
        fin = odo_at_end(r);
      end
    end
    sweep_on    = !fin;
    res.valid   = 1'b1;
    res.offset  = cur_ofs;
    res.stride  = flat ? 48'(sh_outer) : axis_stride(r);
    res.len     = 16'(axis_len(r));
    res.is_last = fin;
    return res;
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, bit [63:0] v);
    case (idx)
      REG_DIM_SIZES:     sh_sizes  = v;
      REG_STRIDES_LO:    sh_str_lo = v;
      REG_STRIDES_HI:    sh_str_hi = v;
      REG_NUM_DIMS:      sh_ndims  = v[2:0];
      REG_TRANSFORM_DIM: sh_tdim   = v[1:0];
      REG_OUTER_STRIDE:  sh_outer  = v[31:0];
      REG_TOTAL_LENGTH:  sh_total  = v[47:0];
      default: ;
    endcase
  endfunction

  function automatic void pred_reset();
    sh_sizes  = 64'h0001_0001_0001_0001;
    sh_str_lo = '0;
    sh_str_hi = '0;
    sh_ndims  = 3'd1;
    sh_tdim   = '0;
    sh_outer  = 32'd1;
    sh_total  = '0;
    for (int i = 0; i < NUM_AXES; i++) axis_cnt[i] = '0;
    cur_ofs   = '0;
    flat_left = '0;
    sweep_on  = 1'b0;
  endfunction

  // Mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [47:0] rand_ofs();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return OFS_MAX;
    return 48'(rand64());
  endfunction

  function automatic bit [15:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(1, 4));
    if (r < 80) return 16'($urandom_range(0, 1));
    if (r < 96) return 16'($urandom_range(5, 12));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic bit [31:0] rand_raw_stride();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic void add_cfg(cfg_reg_t idx, bit [63:0] v);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = v;
    row.func   = FUNC_START;
    row.ofs    = '0;
    row.typed  = 1'b0;
    row.want   = NO_VEC;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_item(func_t f, bit [47:0] ofs, bit typed, vec_res_t want);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = REG_DIM_SIZES;
    row.data   = '0;
    row.func   = f;
    row.ofs    = ofs;
    row.typed  = typed;
    row.want   = want;
    dir_rows.push_back(row);
  endfunction

  task automatic write_reg(cfg_reg_t idx, bit [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg(idx, v);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(func_t f, bit [47:0] ofs, bit typed, vec_res_t want);
    int       gap;
    vec_res_t pred;
    gap = (quiet_phase || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= ofs;
    do @(posedge clk); while (in_tready !== 1'b1);
    pred = next_vector(f, ofs);
    pending_vecs.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Hold off the sender until every pending vector has come back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_vecs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic rand_config(bit all_regs);
    bit [63:0] v;
    int        r;
    settings_used++;
    if (all_regs || $urandom_range(0, 3) != 0) begin
      v = '0;
      for (int i = 0; i < NUM_AXES; i++) v[16*i +: 16] = rand_len();
      write_reg(REG_DIM_SIZES, v);
    end
    if (all_regs || $urandom_range(0, 2) == 0)
      write_reg(REG_STRIDES_LO, {rand_raw_stride(), rand_raw_stride()});
    if (all_regs || $urandom_range(0, 2) == 0)
      write_reg(REG_STRIDES_HI, {rand_raw_stride(), rand_raw_stride()});
    if (all_regs || $urandom_range(0, 1) == 0) begin
      v      = rand64();
      v[2:0] = 3'($urandom_range(0, 7));
      write_reg(REG_NUM_DIMS, v);
    end
    if (all_regs || $urandom_range(0, 1) == 0) begin
      v      = rand64();
      v[1:0] = ($urandom_range(0, 99) < 35) ? 2'd0 : 2'($urandom_range(1, 3));
      write_reg(REG_TRANSFORM_DIM, v);
    end
    if (all_regs || $urandom_range(0, 2) == 0) begin
      v = rand64();
      r = $urandom_range(0, 99);
      if (r < 55)      v[31:0] = $urandom_range(1, 8);
      else if (r < 75) v[31:0] = $urandom | 32'd1;
      else if (r < 88) v[31:0] = '1;
      else             v[31:0] = 32'd1;
      write_reg(REG_OUTER_STRIDE, v);
    end
    if (all_regs || $urandom_range(0, 1) == 0) begin
      v = rand64();
      r = $urandom_range(0, 99);
      if (r < 60)      v[47:0] = 48'($urandom_range(0, 20));
      else if (r < 75) v[47:0] = '0;
      else if (r < 88) v[47:0] = 48'(rand64());
      else             v[47:0] = OFS_MAX;
      write_reg(REG_TOTAL_LENGTH, v);
    end
  endtask

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: ready runs with random stalls in between
  initial begin
    out_tready = 1'b0;
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if ($urandom_range(0, 3) != 0) begin
        out_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_vecs.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected: tuser %b tdata %h", $time,
                 out_tuser, out_tdata);
      end else begin
        head_vec = pending_vecs.pop_front();
        results_seen++;
        check_field("valid_res", 48'(head_vec.valid), 48'(out_tuser));
        check_field("vector_offset", head_vec.offset, out_tdata[47:0]);
        check_field("vector_stride", head_vec.stride, out_tdata[95:48]);
        check_field("vector_length", 48'(head_vec.len), 48'(out_tdata[111:96]));
        check_field("last", 48'(head_vec.is_last), 48'(out_tlast));
      end
    end
  end

  initial begin
    int phase_len;
    bit [47:0] ofs;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    quiet_phase = 1'b0;
    pred_reset();

    // After reset: empty flat sweep and advance while idle
    add_item(FUNC_START, '0, 1'b1, NO_VEC);
    add_item(FUNC_ADVANCE, '0, 1'b1, NO_VEC);
    // Flat sweep of five from the top offset, wrapping through zero
    add_cfg(REG_TOTAL_LENGTH, 64'd5);
    add_item(FUNC_START, OFS_MAX, 1'b1, {1'b1, OFS_MAX, 48'd1, 16'd1, 1'b0});
    repeat (4) add_item(FUNC_ADVANCE, '0, 1'b0, NO_VEC);
    add_item(FUNC_ADVANCE, '0, 1'b1, NO_VEC);
    // Odometer along axis one, with a zero-length axis acting as one
    add_cfg(REG_DIM_SIZES, 64'h0002_0000_0002_0003);
    add_cfg(REG_STRIDES_LO, 64'h0000_0007_0000_0001);
    add_cfg(REG_STRIDES_HI, 64'h0000_0064_0000_000D);
    add_cfg(REG_NUM_DIMS, 64'd4);
    add_cfg(REG_TRANSFORM_DIM, 64'd1);
    add_cfg(REG_OUTER_STRIDE, 64'd3);
    add_item(FUNC_START, 48'h10, 1'b0, NO_VEC);
    repeat (6) add_item(FUNC_ADVANCE, '0, 1'b0, NO_VEC);
    // All-ones extremes, axis count above the limit
    add_cfg(REG_OUTER_STRIDE, 64'hFFFF_FFFF);
    add_cfg(REG_STRIDES_LO, '1);
    add_cfg(REG_STRIDES_HI, '1);
    add_cfg(REG_DIM_SIZES, '1);
    add_cfg(REG_NUM_DIMS, 64'd7);
    add_cfg(REG_TRANSFORM_DIM, 64'd3);
    add_item(FUNC_START, OFS_MAX, 1'b0, NO_VEC);
    repeat (2) add_item(FUNC_ADVANCE, '0, 1'b0, NO_VEC);
    // Axis count zero acts as one; that axis has length one: first is last
    add_cfg(REG_NUM_DIMS, 64'd0);
    add_cfg(REG_TRANSFORM_DIM, 64'd1);
    add_cfg(REG_DIM_SIZES, 64'hFFFF_FFFF_FFFF_0001);
    add_item(FUNC_START, 48'h1234_5678_9ABC, 1'b0, NO_VEC);
    add_item(FUNC_ADVANCE, '0, 1'b1, NO_VEC);
    // Transform axis beyond the axes in use
    add_cfg(REG_NUM_DIMS, 64'd2);
    add_cfg(REG_TRANSFORM_DIM, 64'd3);
    add_cfg(REG_DIM_SIZES, 64'h0000_0000_0002_0002);
    add_item(FUNC_START, 48'h8000_0000_0000, 1'b0, NO_VEC);
    add_item(FUNC_ADVANCE, '0, 1'b0, NO_VEC);
    // Zero flat step never ends
    add_cfg(REG_TRANSFORM_DIM, 64'd0);
    add_cfg(REG_DIM_SIZES, 64'd0);
    add_cfg(REG_OUTER_STRIDE, 64'd1);
    add_cfg(REG_TOTAL_LENGTH, {16'd0, OFS_MAX});
    add_item(FUNC_START, 48'd5, 1'b0, NO_VEC);
    add_item(FUNC_ADVANCE, '0, 1'b0, NO_VEC);
    // Scaled total length wraps to zero: empty sweep
    add_cfg(REG_TOTAL_LENGTH, 64'h8000_0000_0000);
    add_cfg(REG_OUTER_STRIDE, 64'd2);
    add_item(FUNC_START, 48'hABC, 1'b1, NO_VEC);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        wait_drain();
        write_reg(dir_rows[k].idx, dir_rows[k].data);
      end else begin
        send_item(dir_rows[k].func, dir_rows[k].ofs, dir_rows[k].typed, dir_rows[k].want);
      end
    end
    directed_items = items_sent;

    // Random phases: mostly complete sweeps, some restarts and idle advances
    while (items_sent < directed_items + 950) begin
      wait_drain();
      rand_config(settings_used == 0);
      quiet_phase = ($urandom_range(0, 3) == 0);
      phase_len   = $urandom_range(20, 80);
      repeat (phase_len) begin
        if ($urandom_range(0, 49) == 0) wait_drain();
        ofs = rand_ofs();
        if (sweep_on)
          send_item(($urandom_range(0, 99) < 92) ? FUNC_ADVANCE : FUNC_START, ofs, 1'b0, NO_VEC);
        else
          send_item(($urandom_range(0, 99) < 85) ? FUNC_START : FUNC_ADVANCE, ofs, 1'b0, NO_VEC);
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    $display("covered %0d input beats (%0d directed), %0d result beats checked,", items_sent,
             directed_items, results_seen);
    $display("%0d register writes over %0d random axis setups", cfg_writes, settings_used);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
